/* hdl/mrf_pkg.sv */
// mrf_pkg: shared types and constants for the matrix rectangle fill core
// holds stream field widths, opcodes, command kinds and the command record
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mrf_pkg;

  // default geometry
  localparam int ROWS_DEF        = 128;
  localparam int COLS_DEF        = 128;
  localparam int VALUE_WIDTH_DEF = 32;

  // stream field widths
  localparam int OP_W        = 2;
  localparam int COORD_W     = 7;
  localparam int FIELD_W     = 32;
  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = OP_W;
  localparam int OUT_TDATA_W = FIELD_W;
  localparam int OUT_TUSER_W = 1;

  // wide enough to compare any coordinate with any legal geometry
  localparam int IDX_W = 13;

  // command queue depth
  localparam int CMD_FIFO_DEPTH = 2;

  // opcodes on the input stream
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_FILL  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // what the engine does with a command
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_FILL = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  // classified command, bounds already clipped to the store
  typedef struct packed {
    kind_t              kind;
    logic               hit;
    logic [COORD_W-1:0] row_lo;
    logic [COORD_W-1:0] row_hi;
    logic [COORD_W-1:0] col_lo;
    logic [COORD_W-1:0] col_hi;
    logic [FIELD_W-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

/* hdl/matrix_rectangle_fill_core.sv */
// matrix_rectangle_fill_core: top level of the rectangle fill store
// ties front, command queue and engine together; depends on mrf_pkg
`timescale 1ns / 1ps
`default_nettype none

// A ROWS x COLS store of VALUE_WIDTH-bit words driven by one input stream.
// in_tuser carries the opcode: write one cell, fill an inclusive rectangle
// with one value, or read one cell; every input transaction returns exactly
// one output transaction, carrying the cell value for a read (out_tuser set)
// and zero for everything else. Fills with the last row or column before
// the first do nothing, and rectangles are clipped to the store. The store
// comes up undefined: read only cells already written. There is no clearing
// pass after reset. A fill is swept by the single row-wide write port,
// which writes one row span of the rectangle per cycle. A two-entry
// command queue lets the input side keep accepting while the engine sweeps
// a fill or a result waits on out_tready.

module matrix_rectangle_fill_core
  import mrf_pkg::*;
#(
  parameter int ROWS        = ROWS_DEF,
  parameter int COLS        = COLS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // row_first[6:0], col_first[13:7], row_last[20:14], col_last[27:21],
  // fill_value[59:28], zero fill above
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // op[1:0]
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // read_data[31:0]
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // was_read[0]
  output logic [OUT_TUSER_W-1:0]      out_tuser
);

  cmd_t q_in_cmd, q_out_cmd;
  logic q_push, q_full, q_pop, q_not_empty;

  // decode and clip incoming transactions
  mrf_front #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in_cmd)
  );

  // decouples acceptance from execution
  mrf_cmd_fifo #(
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_in_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .rdata     (q_out_cmd),
    .not_empty (q_not_empty)
  );

  // store, row sweep and output register
  mrf_engine #(
    .ROWS        (ROWS),
    .COLS        (COLS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_not_empty),
    .cmd        (q_out_cmd),
    .cmd_pop    (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

/* hdl/mrf_front.sv */
// mrf_front: accepts input transactions and turns them into engine commands
// a single-cell write becomes a 1x1 fill; depends on mrf_pkg
`timescale 1ns / 1ps
`default_nettype none

module mrf_front
  import mrf_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic [IN_TUSER_W-1:0] in_tuser,
  input  wire logic                  q_full,
  output logic                       q_push,
  output cmd_t                       q_cmd
);

  logic [OP_W-1:0]    op;
  logic [COORD_W-1:0] r0, c0, r1, c1;
  logic [FIELD_W-1:0] val;
  logic               r0_ok, c0_ok, empty;
  logic [COORD_W-1:0] r1_clip, c1_clip;

  assign op  = in_tuser[OP_W-1:0];
  assign r0  = in_tdata[6:0];
  assign c0  = in_tdata[13:7];
  assign r1  = in_tdata[20:14];
  assign c1  = in_tdata[27:21];
  assign val = in_tdata[59:28];

  assign r0_ok = IDX_W'(r0) < IDX_W'(ROWS);
  assign c0_ok = IDX_W'(c0) < IDX_W'(COLS);
  assign empty = (r1 < r0) || (c1 < c0);

  // clip the far corner to the store
  assign r1_clip = (IDX_W'(r1) >= IDX_W'(ROWS)) ? COORD_W'(ROWS - 1) : r1;
  assign c1_clip = (IDX_W'(c1) >= IDX_W'(COLS)) ? COORD_W'(COLS - 1) : c1;

  always_comb begin
    q_cmd        = '0;
    q_cmd.kind   = KIND_NONE;
    q_cmd.hit    = r0_ok && c0_ok;
    q_cmd.row_lo = r0;
    q_cmd.col_lo = c0;
    q_cmd.row_hi = r0;
    q_cmd.col_hi = c0;
    q_cmd.value  = val;
    case (op)
      OP_WRITE: begin
        if (r0_ok && c0_ok) q_cmd.kind = KIND_FILL;
      end
      OP_FILL: begin
        q_cmd.row_hi = r1_clip;
        q_cmd.col_hi = c1_clip;
        if (!empty && r0_ok && c0_ok) q_cmd.kind = KIND_FILL;
      end
      OP_READ: begin
        q_cmd.kind = KIND_READ;
      end
      default: begin
        q_cmd.kind = KIND_NONE;
      end
    endcase
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

endmodule

`default_nettype wire

/* hdl/mrf_cmd_fifo.sv */
// mrf_cmd_fifo: short command queue between front and engine
// depends on mrf_pkg for the command record
`timescale 1ns / 1ps
`default_nettype none

module mrf_cmd_fifo
  import mrf_pkg::*;
#(
  parameter int DEPTH = CMD_FIFO_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t wdata,
  output logic      full,
  input  wire logic pop,
  output cmd_t      rdata,
  output logic      not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = cnt_r == CNT_W'(DEPTH);
  assign not_empty = cnt_r != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rdata     = slots_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots_r[wptr_r] <= wdata;
  end

endmodule

`default_nettype wire

/* hdl/mrf_engine.sv */
// mrf_engine: executes commands against the row-wide cell store
// one row span written per cycle for fills; depends on mrf_pkg
`timescale 1ns / 1ps
`default_nettype none

module mrf_engine
  import mrf_pkg::*;
#(
  parameter int ROWS        = ROWS_DEF,
  parameter int COLS        = COLS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cmd_valid,
  input  wire cmd_t                   cmd,
  output logic                        cmd_pop,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic [OUT_TUSER_W-1:0]      out_tuser
);

  localparam int RAW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CAW = (COLS > 1) ? $clog2(COLS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_FILL = 4'b0010,
    ST_READ = 4'b0100,
    ST_RESP = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  cmd_t               cur_r, cur_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;

  // cell store: one row of words per entry, per-word write enable
  logic [COLS-1:0][VALUE_WIDTH-1:0] mem [ROWS];
  logic [COLS-1:0][VALUE_WIDTH-1:0] rd_row_r;
  logic [COLS-1:0]                  col_mask;
  logic                             wr_en, rd_en;
  logic [VALUE_WIDTH-1:0]           wr_val;

  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [FIELD_W-1:0]     out_data_r, out_data_nxt;
  logic                   out_read_r, out_read_nxt;
  logic                   slot_free;
  logic [VALUE_WIDTH-1:0] rd_word;

  assign slot_free = !out_tvalid_r || out_tready;
  assign cmd_pop   = (state_r == ST_IDLE) && cmd_valid;

  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      col_mask[c] = (IDX_W'(c) >= IDX_W'(cur_r.col_lo)) &&
                    (IDX_W'(c) <= IDX_W'(cur_r.col_hi));
    end
  end

  assign wr_en   = state_r == ST_FILL;
  assign wr_val  = VALUE_WIDTH'(cur_r.value);
  assign rd_en   = cmd_pop && (cmd.kind == KIND_READ);
  assign rd_word = rd_row_r[CAW'(cur_r.col_lo)];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int c = 0; c < COLS; c++) begin
        if (col_mask[c]) mem[RAW'(row_r)][c] <= wr_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_row_r <= mem[RAW'(cmd.row_lo)];
  end

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    row_nxt        = row_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_read_nxt   = out_read_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cur_nxt = cmd;
          row_nxt = cmd.row_lo;
          case (cmd.kind)
            KIND_FILL: state_nxt = ST_FILL;
            KIND_READ: state_nxt = ST_READ;
            default:   state_nxt = ST_RESP;
          endcase
        end
      end
      ST_FILL: begin
        if (row_r == cur_r.row_hi) begin
          state_nxt = ST_RESP;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end
      ST_READ: begin
        // read row is already in rd_row_r, captured as the command was popped
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (slot_free) begin
          out_tvalid_nxt = 1'b1;
          out_read_nxt   = cur_r.kind == KIND_READ;
          out_data_nxt   = (cur_r.kind == KIND_READ && cur_r.hit) ?
                           FIELD_W'(rd_word) : '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    row_r      <= row_nxt;
    out_data_r <= out_data_nxt;
    out_read_r <= out_read_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_read_r;

  // fill sweep never passes the clipped bottom row
  a_fill_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FILL |-> row_r <= cur_r.row_hi)
    else $error("fill row counter ran past bottom row");

  // a fill command starts its sweep at its top row
  a_fill_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && cmd.kind == KIND_FILL) |=> (state_r == ST_FILL && row_r == $past(cmd.row_lo)))
    else $error("fill did not start at top row");

  // a result appears only when the engine leaves the response state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ST_RESP))
    else $error("result produced outside response state");

  // a read leaves ST_READ for the response state without stalling
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> state_r == ST_RESP)
    else $error("read did not reach response state");

endmodule

`default_nettype wire
